// ===== src/ophist_pkg.sv =====
// Shared types, constants and helpers for the overlapping pattern histogram.
`default_nettype none

package ophist_pkg;

    localparam int MAX_WINDOW  = 10;
    localparam int SHORT_AW    = MAX_WINDOW;
    localparam int LONG_AW     = MAX_WINDOW + 1;
    localparam int COUNT_W     = 32;
    localparam int BITS_W      = 32;
    localparam int LEN_W       = 4;
    localparam int IDX_W       = 11;
    localparam int MARGIN_LOG2 = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FEW   = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_PUSH,
        CMD_FINISH,
        CMD_READ,
        CMD_READ_BAD,
        CMD_CLEAR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic             bit_val;
        logic             table_sel;
        logic [IDX_W-1:0] index;
    } cmd_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_WRAP,
        B_READ,
        B_WRITE
    } back_state_t;

    // Clamp the programmed length into 1..MAX_WINDOW.
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] m;
        m = raw;
        if (raw == '0) begin
            m = LEN_W'(1);
        end
        else if (raw > LEN_W'(MAX_WINDOW)) begin
            m = LEN_W'(MAX_WINDOW);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/overlapping_pattern_histogram_core.sv =====
// Top level of the overlapping pattern histogram: length register, front end, queue, engine.
`default_nettype none

// Commands enter on start when busy is low and land in a two-entry queue; the
// engine works them one at a time and reports each on a one-cycle done strobe
// that cannot be stalled, so take count, total_bits and status on that cycle.
// Count memories have a registered read. A push reads, increments and writes;
// a read reads and reports; a finish with wraparound does those steps per
// leading bit; a rejected read, refused or repeated finish, or push after finish
// skips the memories. Clear writes one memory row per cycle; after reset such a
// pass keeps busy high. Write window_length only while no command is outstanding.
module overlapping_pattern_histogram_core
    import ophist_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         operation,
    input  wire logic               bit_req,
    input  wire logic               table_select,
    input  wire logic [IDX_W-1:0]   pattern_index,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LEN_W-1:0]   cfg_data,
    output logic                    done,
    output logic [COUNT_W-1:0]      count,
    output logic [BITS_W-1:0]       total_bits,
    output logic [1:0]              status
);

    logic [LEN_W-1:0] window_length_reg;
    logic [LEN_W-1:0] window_length_next;
    logic [LEN_W-1:0] m;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_empty;
    logic             back_init;
    cmd_t             front_cmd;
    cmd_t             head_cmd;

    assign cfg_ready          = 1'b1;
    assign window_length_next = (cfg_valid && cfg_ready) ? cfg_data : window_length_reg;
    assign m                  = eff_len(window_length_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            window_length_reg <= LEN_RESET;
        end
        else begin
            window_length_reg <= window_length_next;
        end
    end

    ophist_front u_front (
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .bit_req       (bit_req),
        .table_select  (table_select),
        .pattern_index (pattern_index),
        .m             (m),
        .q_full        (q_full),
        .back_init     (back_init),
        .q_wr          (q_wr),
        .q_cmd         (front_cmd)
    );

    ophist_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .wdata (front_cmd),
        .full  (q_full),
        .rd    (q_rd),
        .rdata (head_cmd),
        .empty (q_empty)
    );

    ophist_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .m          (m),
        .q_empty    (q_empty),
        .q_cmd      (head_cmd),
        .q_rd       (q_rd),
        .init_busy  (back_init),
        .done       (done),
        .count      (count),
        .total_bits (total_bits),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== src/ophist_front.sv =====
// Command front end: takes transactions, decodes them and range-checks reads.
`default_nettype none

module ophist_front
    import ophist_pkg::*;
(
    input  wire logic             start,
    output logic                  busy,
    input  wire logic [1:0]       operation,
    input  wire logic             bit_req,
    input  wire logic             table_select,
    input  wire logic [IDX_W-1:0] pattern_index,
    input  wire logic [LEN_W-1:0] m,
    input  wire logic             q_full,
    input  wire logic             back_init,
    output logic                  q_wr,
    output cmd_t                  q_cmd
);

    logic             out_of_range;
    logic [IDX_W-1:0] short_over;
    logic [IDX_W-1:0] long_over;

    // Any bit above the table's address width means the index is outside it.
    assign short_over   = pattern_index >> m;
    assign long_over    = pattern_index >> (m + LEN_W'(1));
    assign out_of_range = table_select ? (long_over != '0) : (short_over != '0);

    assign busy = q_full | back_init;
    assign q_wr = start & ~busy;

    always_comb
    begin
        q_cmd.bit_val   = bit_req;
        q_cmd.table_sel = table_select;
        q_cmd.index     = pattern_index;
        case (op_t'(operation))
            OP_PUSH:   q_cmd.kind = CMD_PUSH;
            OP_FINISH: q_cmd.kind = CMD_FINISH;
            OP_READ:   q_cmd.kind = out_of_range ? CMD_READ_BAD : CMD_READ;
            OP_CLEAR:  q_cmd.kind = CMD_CLEAR;
            default:   q_cmd.kind = CMD_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/ophist_queue.sv =====
// Short command queue between the front end and the execution engine.
`default_nettype none

module ophist_queue
    import ophist_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wdata,
    output logic      full,
    input  wire logic rd,
    output cmd_t      rdata,
    output logic      empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg;
    logic [QCNT_W-1:0] fill_next;
    logic              do_wr;
    logic              do_rd;

    assign full  = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign rdata = entry_reg[rd_ptr_reg];
    assign do_wr = wr & ~full;
    assign do_rd = rd & ~empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr) begin
            fill_next = fill_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/ophist_back.sv =====
// Execution engine: window state, pattern count memories, wraparound and clear sweep.
`default_nettype none

module ophist_back
    import ophist_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [LEN_W-1:0]   m,
    input  wire logic               q_empty,
    input  wire cmd_t               q_cmd,
    output logic                    q_rd,
    output logic                    init_busy,
    output logic                    done,
    output logic [COUNT_W-1:0]      count,
    output logic [BITS_W-1:0]       total_bits,
    output logic [1:0]              status
);

    logic [COUNT_W-1:0] short_mem [2**SHORT_AW];
    logic [COUNT_W-1:0] long_mem  [2**LONG_AW];

    back_state_t         state_reg,      state_next;
    logic [LONG_AW-1:0]  window_reg,     window_next;
    logic [SHORT_AW-1:0] leading_reg,    leading_next;
    logic [BITS_W-1:0]   bits_seen_reg,  bits_seen_next;
    logic                finished_reg,   finished_next;
    logic [SHORT_AW-1:0] short_addr_reg, short_addr_next;
    logic [LONG_AW-1:0]  long_addr_reg,  long_addr_next;
    logic                short_en_reg,   short_en_next;
    logic                long_en_reg,    long_en_next;
    cmd_kind_t           kind_reg,       kind_next;
    logic                table_sel_reg,  table_sel_next;
    logic [LEN_W-1:0]    step_reg,       step_next;
    logic [LONG_AW-1:0]  clr_addr_reg,   clr_addr_next;
    logic                init_reg,       init_next;
    logic                clear_ack_reg,  clear_ack_next;
    logic                done_reg,       done_next;
    logic [COUNT_W-1:0]  count_reg,      count_next;
    status_t             status_reg,     status_next;

    logic [COUNT_W-1:0]  short_rdata_reg;
    logic [COUNT_W-1:0]  long_rdata_reg;

    logic                mem_rd;
    logic                short_we;
    logic                long_we;
    logic [SHORT_AW-1:0] short_waddr;
    logic [LONG_AW-1:0]  long_waddr;
    logic [COUNT_W-1:0]  short_wdata;
    logic [COUNT_W-1:0]  long_wdata;

    logic [SHORT_AW-1:0] short_mask;
    logic [LONG_AW-1:0]  long_mask;
    logic [LONG_AW-1:0]  win_push;
    logic [LONG_AW-1:0]  win_wrap;
    logic [BITS_W-1:0]   bits_inc;
    logic [BITS_W-1:0]   few_limit;
    logic [BITS_W-1:0]   m_wide;
    logic [LEN_W-1:0]    lead_idx;

    assign short_mask = ~({SHORT_AW{1'b1}} << m);
    assign long_mask  = ~({LONG_AW{1'b1}} << (m + LEN_W'(1)));
    assign win_push   = {window_reg[LONG_AW-2:0], q_cmd.bit_val};
    assign lead_idx   = m - LEN_W'(1) - step_reg;
    assign win_wrap   = {window_reg[LONG_AW-2:0], leading_reg[lead_idx]};
    assign bits_inc   = (bits_seen_reg == '1) ? bits_seen_reg : bits_seen_reg + BITS_W'(1);
    assign few_limit  = BITS_W'(1) << (m + LEN_W'(MARGIN_LOG2));
    assign m_wide     = BITS_W'(m);

    assign init_busy  = init_reg;
    assign done       = done_reg;
    assign count      = count_reg;
    assign status     = status_reg;
    assign total_bits = bits_seen_reg;

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        leading_next    = leading_reg;
        bits_seen_next  = bits_seen_reg;
        finished_next   = finished_reg;
        short_addr_next = short_addr_reg;
        long_addr_next  = long_addr_reg;
        short_en_next   = short_en_reg;
        long_en_next    = long_en_reg;
        kind_next       = kind_reg;
        table_sel_next  = table_sel_reg;
        step_next       = step_reg;
        clr_addr_next   = clr_addr_reg;
        init_next       = init_reg;
        clear_ack_next  = clear_ack_reg;
        done_next       = 1'b0;
        count_next      = count_reg;
        status_next     = status_reg;
        q_rd            = 1'b0;
        mem_rd          = 1'b0;
        short_we        = 1'b0;
        long_we         = 1'b0;
        short_waddr     = short_addr_reg;
        long_waddr      = long_addr_reg;
        short_wdata     = short_rdata_reg + COUNT_W'(1);
        long_wdata      = long_rdata_reg + COUNT_W'(1);

        case (state_reg)
            B_CLEAR:
            begin
                short_we      = 1'b1;
                long_we       = 1'b1;
                short_waddr   = clr_addr_reg[SHORT_AW-1:0];
                long_waddr    = clr_addr_reg;
                short_wdata   = '0;
                long_wdata    = '0;
                clr_addr_next = clr_addr_reg + LONG_AW'(1);
                if (clr_addr_reg == '1) begin
                    init_next  = 1'b0;
                    state_next = B_IDLE;
                    if (clear_ack_reg) begin
                        clear_ack_next = 1'b0;
                        done_next      = 1'b1;
                        count_next     = '0;
                        status_next    = STATUS_OK;
                    end
                end
            end

            B_IDLE:
            begin
                if (!q_empty) begin
                    q_rd        = 1'b1;
                    kind_next   = q_cmd.kind;
                    count_next  = '0;
                    status_next = STATUS_OK;
                    case (q_cmd.kind)
                        CMD_PUSH:
                        begin
                            if (finished_reg) begin
                                done_next = 1'b1;
                            end
                            else begin
                                if (bits_seen_reg < m_wide) begin
                                    leading_next = {leading_reg[SHORT_AW-2:0], q_cmd.bit_val};
                                end
                                window_next     = win_push;
                                bits_seen_next  = bits_inc;
                                short_addr_next = win_push[SHORT_AW-1:0] & short_mask;
                                long_addr_next  = win_push & long_mask;
                                short_en_next   = (bits_inc >= m_wide);
                                long_en_next    = (bits_inc >= m_wide + BITS_W'(1));
                                state_next      = B_READ;
                            end
                        end
                        CMD_FINISH:
                        begin
                            if (finished_reg) begin
                                done_next = 1'b1;
                            end
                            else if (bits_seen_reg <= few_limit) begin
                                done_next   = 1'b1;
                                status_next = STATUS_FEW;
                            end
                            else begin
                                step_next  = '0;
                                state_next = B_WRAP;
                            end
                        end
                        CMD_READ:
                        begin
                            short_addr_next = q_cmd.index[SHORT_AW-1:0];
                            long_addr_next  = q_cmd.index;
                            table_sel_next  = q_cmd.table_sel;
                            short_en_next   = 1'b0;
                            long_en_next    = 1'b0;
                            state_next      = B_READ;
                        end
                        CMD_READ_BAD:
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_RANGE;
                        end
                        CMD_CLEAR:
                        begin
                            window_next    = '0;
                            leading_next   = '0;
                            bits_seen_next = '0;
                            finished_next  = 1'b0;
                            clr_addr_next  = '0;
                            clear_ack_next = 1'b1;
                            state_next     = B_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            B_WRAP:
            begin
                // Feed the next leading bit back in, oldest first.
                window_next     = win_wrap;
                short_addr_next = win_wrap[SHORT_AW-1:0] & short_mask;
                long_addr_next  = win_wrap & long_mask;
                short_en_next   = (step_reg + LEN_W'(1)) < m;
                long_en_next    = 1'b1;
                state_next      = B_READ;
            end

            B_READ:
            begin
                mem_rd     = 1'b1;
                state_next = B_WRITE;
            end

            B_WRITE:
            begin
                if (kind_reg == CMD_READ) begin
                    done_next  = 1'b1;
                    count_next = table_sel_reg ? long_rdata_reg : short_rdata_reg;
                    state_next = B_IDLE;
                end
                else begin
                    // Saturating increment: hold a count that is already full.
                    short_we = short_en_reg & (short_rdata_reg != '1);
                    long_we  = long_en_reg & (long_rdata_reg != '1);
                    if (kind_reg == CMD_PUSH) begin
                        done_next  = 1'b1;
                        state_next = B_IDLE;
                    end
                    else if (step_reg == m - LEN_W'(1)) begin
                        finished_next = 1'b1;
                        done_next     = 1'b1;
                        state_next    = B_IDLE;
                    end
                    else begin
                        step_next  = step_reg + LEN_W'(1);
                        state_next = B_WRAP;
                    end
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_CLEAR;
            window_reg    <= '0;
            leading_reg   <= '0;
            bits_seen_reg <= '0;
            finished_reg  <= 1'b0;
            kind_reg      <= CMD_PUSH;
            step_reg      <= '0;
            clr_addr_reg  <= '0;
            init_reg      <= 1'b1;
            clear_ack_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            leading_reg   <= leading_next;
            bits_seen_reg <= bits_seen_next;
            finished_reg  <= finished_next;
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            clr_addr_reg  <= clr_addr_next;
            init_reg      <= init_next;
            clear_ack_reg <= clear_ack_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        short_addr_reg <= short_addr_next;
        long_addr_reg  <= long_addr_next;
        short_en_reg   <= short_en_next;
        long_en_reg    <= long_en_next;
        table_sel_reg  <= table_sel_next;
        count_reg      <= count_next;
        status_reg     <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (short_we) begin
            short_mem[short_waddr] <= short_wdata;
        end
        if (mem_rd) begin
            short_rdata_reg <= short_mem[short_addr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (long_we) begin
            long_mem[long_waddr] <= long_wdata;
        end
        if (mem_rd) begin
            long_rdata_reg <= long_mem[long_addr_reg];
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for overlapping_pattern_histogram_core.
module tb;
    import ophist_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned FEW_MARGIN  = 5;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [BITS_W-1:0]  total;
        status_t            status;
    } answer_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         operation;
    logic               bit_req;
    logic               table_select;
    logic [IDX_W-1:0]   pattern_index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LEN_W-1:0]   cfg_data;
    logic               done;
    logic [COUNT_W-1:0] count;
    logic [BITS_W-1:0]  total_bits;
    logic [1:0]         status;

    // Mirror of the block's state
    logic [COUNT_W-1:0] short_hist [0:(1<<SHORT_AW)-1];
    logic [COUNT_W-1:0] long_hist [0:(1<<LONG_AW)-1];
    logic [LONG_AW-1:0] window_reg;
    logic [MAX_WINDOW-1:0] lead_reg;
    logic [BITS_W-1:0]  pushed_bits;
    bit                 wrapped;
    logic [LEN_W-1:0]   len_setting;

    answer_t     answers_due[$];
    int unsigned mismatches  = 0;
    int unsigned items_sent  = 0;
    int unsigned idle_pct    = 0;
    int unsigned cycle_count = 0;

    overlapping_pattern_histogram_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .bit_req       (bit_req),
        .table_select  (table_select),
        .pattern_index (pattern_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .count         (count),
        .total_bits    (total_bits),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int unsigned active_len();
        if (len_setting == '0)
            return 1;
        if (len_setting > LEN_W'(MAX_WINDOW))
            return MAX_WINDOW;
        return int'(len_setting);
    endfunction

    function automatic void wipe_histograms();
        foreach (short_hist[i])
            short_hist[i] = '0;
        foreach (long_hist[i])
            long_hist[i] = '0;
        window_reg  = '0;
        lead_reg    = '0;
        pushed_bits = '0;
        wrapped     = 1'b0;
    endfunction

    function automatic void tally(logic [LONG_AW-1:0] w, int unsigned m, bit do_short,
                                  bit do_long);
        int unsigned s_idx;
        int unsigned l_idx;
        s_idx = int'(w) & ((1 << m) - 1);
        l_idx = int'(w) & ((1 << (m + 1)) - 1);
        if (do_short && short_hist[s_idx] != '1)
            short_hist[s_idx]++;
        if (do_long && long_hist[l_idx] != '1)
            long_hist[l_idx]++;
    endfunction

    // Advance the mirrored state by one command and return the answer it produces.
    function automatic answer_t predict_answer(op_t op, logic b, logic sel,
                                               logic [IDX_W-1:0] idx);
        answer_t             ans;
        int unsigned         m;
        int unsigned         depth;
        longint unsigned     few_limit;
        logic [LONG_AW-1:0]  w;
        m = active_len();
        ans.count  = '0;
        ans.status = STATUS_OK;
        case (op)
            OP_PUSH:
            begin
                if (!wrapped)
                begin
                    if (pushed_bits < m)
                        lead_reg = {lead_reg[MAX_WINDOW-2:0], b};
                    window_reg = {window_reg[LONG_AW-2:0], b};
                    if (pushed_bits != '1)
                        pushed_bits++;
                    tally(window_reg, m, pushed_bits >= m, pushed_bits >= m + 1);
                end
            end
            OP_FINISH:
            begin
                if (!wrapped)
                begin
                    few_limit = 64'd1 << (m + FEW_MARGIN);
                    if (longint'(pushed_bits) <= few_limit)
                        ans.status = STATUS_FEW;
                    else
                    begin
                        // Feed the leading bits again, oldest first
                        w = window_reg;
                        for (int unsigned i = 0; i < m; i++)
                        begin
                            w = {w[LONG_AW-2:0], lead_reg[m-1-i]};
                            tally(w, m, i + 1 < m, 1'b1);
                        end
                        window_reg = w;
                        wrapped    = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                depth = sel ? (1 << (m + 1)) : (1 << m);
                if (idx >= depth)
                    ans.status = STATUS_RANGE;
                else
                    ans.count = sel ? long_hist[idx] : short_hist[idx[SHORT_AW-1:0]];
            end
            default:
                wipe_histograms();
        endcase
        ans.total = pushed_bits;
        return ans;
    endfunction

    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                $error("unexpected result: count %0d total_bits %0d status %0d",
                       count, total_bits, status);
                mismatches++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (count !== want.count)
                begin
                    $error("count mismatch: expected %0d, got %0d", want.count, count);
                    mismatches++;
                end
                if (total_bits !== want.total)
                begin
                    $error("total_bits mismatch: expected %0d, got %0d", want.total,
                           total_bits);
                    mismatches++;
                end
                if (status !== want.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
            end
        end
    end

    task automatic issue_command(input op_t op, input logic b, input logic sel,
                                 input logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        bit_req       <= b;
        table_select  <= sel;
        pattern_index <= idx;
        do
            @(posedge clk);
        while (busy);
        answers_due.push_back(predict_answer(op, b, sel, idx));
        items_sent++;
    endtask

    task automatic push_bit(input logic b);
        issue_command(OP_PUSH, b, 1'($urandom), IDX_W'($urandom));
    endtask

    task automatic read_count(input logic sel, input int unsigned idx);
        issue_command(OP_READ, 1'($urandom), sel, IDX_W'(idx));
    endtask

    task automatic finish_seq();
        issue_command(OP_FINISH, 1'($urandom), 1'($urandom), IDX_W'($urandom));
    endtask

    task automatic clear_all();
        issue_command(OP_CLEAR, 1'($urandom), 1'($urandom), IDX_W'($urandom));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] raw);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= raw;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        len_setting = raw;
    endtask

    task automatic read_all_patterns();
        int unsigned m;
        m = active_len();
        for (int unsigned i = 0; i < (1 << m); i++)
            read_count(1'b0, i);
        for (int unsigned i = 0; i < (1 << (m + 1)); i++)
            read_count(1'b1, i);
    endtask

    task automatic test_after_reset();
        read_count(1'b0, 0);
        read_count(1'b0, 3);
        read_count(1'b0, 4);
        read_count(1'b1, 7);
        read_count(1'b1, 8);
        read_count(1'b1, 2047);
        finish_seq();
        push_bit(1'b1);
        read_count(1'b0, 0);
        clear_all();
    endtask

    task automatic test_length_limits();
        write_length(LEN_W'(0));
        push_bit(1'b1);
        push_bit(1'b0);
        read_count(1'b0, 1);
        read_count(1'b0, 2);
        read_count(1'b1, 2);
        read_count(1'b1, 4);
        write_length(LEN_W'(15));
        read_count(1'b0, 1023);
        read_count(1'b0, 1024);
        read_count(1'b1, 2047);
        write_length(LEN_W'(11));
        read_count(1'b1, 0);
        write_length(LEN_W'(10));
        read_count(1'b0, 1023);
        clear_all();
    endtask

    // Exactly the threshold is refused; one more bit lets the wraparound happen.
    task automatic test_wraparound();
        write_length(LEN_W'(1));
        clear_all();
        for (int i = 0; i < 64; i++)
            push_bit(1'($urandom));
        finish_seq();
        push_bit(1'b1);
        finish_seq();
        finish_seq();
        push_bit(1'b0);
        read_all_patterns();
    endtask

    task automatic test_length_change();
        write_length(LEN_W'(2));
        clear_all();
        for (int i = 0; i < 40; i++)
            push_bit(1'($urandom));
        write_length(LEN_W'(3));
        for (int i = 0; i < 230; i++)
            push_bit(1'($urandom));
        finish_seq();
        read_all_patterns();
    endtask

    task automatic test_long_window();
        write_length(LEN_W'(10));
        clear_all();
        for (int i = 0; i < 200; i++)
            push_bit(1'($urandom));
        read_count(1'b0, $urandom_range(1023));
        read_count(1'b1, $urandom_range(2047));
        read_count(1'b0, 0);
        read_count(1'b1, 2047);
        finish_seq();
    endtask

    task automatic run_noise();
        int unsigned n;
        n = $urandom_range(20, 40);
        repeat (n)
            issue_command(op_t'($urandom_range(3)), 1'($urandom), 1'($urandom),
                          IDX_W'($urandom));
    endtask

    // One run: pick a length, clear, a stream with random reads mixed in, finish, read back.
    task automatic run_sequence();
        int unsigned pick;
        int unsigned m;
        int unsigned few_limit;
        int unsigned n_push;
        int unsigned bias;
        bit          early;
        bit          shift_len;
        pick = $urandom_range(9);
        if (pick == 0)
            write_length(LEN_W'(0));
        else if (pick <= 5)
            write_length(LEN_W'(1));
        else if (pick <= 8)
            write_length(LEN_W'(2));
        else
            write_length(LEN_W'(3));
        clear_all();
        m         = active_len();
        few_limit = 1 << (m + FEW_MARGIN);
        n_push    = few_limit + $urandom_range(1, 16);
        bias      = $urandom_range(100);
        early     = ($urandom_range(3) == 0);
        shift_len = ($urandom_range(9) == 0);
        for (int unsigned i = 0; i < n_push; i++)
        begin
            if (early && i == few_limit)
                finish_seq();
            if (shift_len && i == n_push / 2)
                write_length(LEN_W'($urandom_range(1, 2)));
            if ($urandom_range(19) == 0)
            begin
                if ($urandom_range(3) == 0)
                    read_count(1'($urandom), $urandom_range(2047));
                else
                    read_count(1'($urandom), $urandom_range((1 << m) - 1));
            end
            push_bit($urandom_range(99) < bias);
        end
        finish_seq();
        if ($urandom_range(1))
            finish_seq();
        if ($urandom_range(1))
            push_bit(1'($urandom));
        read_all_patterns();
        read_count(1'($urandom), $urandom_range(2047));
    endtask

    task automatic test_random_phase(input int unsigned pct, input int unsigned quota);
        int unsigned stop_at;
        idle_pct = pct;
        stop_at  = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(6) == 0)
                run_noise();
            else
                run_sequence();
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        start         <= 1'b0;
        operation     <= OP_PUSH;
        bit_req       <= 1'b0;
        table_select  <= 1'b0;
        pattern_index <= '0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        len_setting   = LEN_RESET;
        wipe_histograms();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 10;
        test_after_reset();
        test_length_limits();
        test_wraparound();
        test_length_change();
        test_long_window();

        test_random_phase(10, 250);
        test_random_phase(77, 250);
        test_random_phase(0, 250);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
